### design/abpc_pkg.sv
// Package for the aligned burst packet counter.
// Widths, command codes, chunk descriptor and divider request/response types,
// and state types shared by every design file. No dependencies.
package abpc_pkg;

  // Request and result field widths
  localparam int CMD_W   = 2;
  localparam int ADDR_W  = 32;
  localparam int LEN_W   = 16;
  localparam int TGT_W   = 8;
  localparam int FAC_W   = 4;
  localparam int COUNT_W = 24;

  // Packet size and alignment
  localparam int MAX_PACKET_WORDS = 256;
  localparam int MAX_LOG2         = $clog2(MAX_PACKET_WORDS);
  localparam int ALIGN_W          = 2;
  localparam int ALIGN_WORDS      = 4;
  localparam int PAD_MIN_LEN      = 8;

  // Derived datapath widths
  localparam int CHUNK_W    = MAX_LOG2 + 1;          // chunk size 1..MAX
  localparam int RUN_W      = LEN_W - MAX_LOG2;      // number of equal full chunks
  localparam int PKT_W      = TGT_W + 1;             // packets for one chunk
  localparam int STEP_W     = CHUNK_W + FAC_W;       // target stride
  localparam int PROD_W     = PKT_W + RUN_W;         // packets for one run
  localparam int DIV_CNT_W  = $clog2(CHUNK_W + 1);

  // Chunk queue between front and back
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // Command classes that produce packets
  localparam logic [CMD_W-1:0] CMD_SAME_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SEQ        = 2'd1;

  // One run of equal chunks handed from the splitter to the counter
  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [TGT_W-1:0]   first_target;
    logic [TGT_W-1:0]   last_target;
    logic [FAC_W-1:0]   factor;
    logic [CHUNK_W-1:0] chunk;
    logic [RUN_W-1:0]   run_len;
    logic               empty;     // zero-length request, counts nothing
    logic               last_run;  // closes the request
  } chunk_desc_t;

  typedef struct packed {
    logic               start;
    logic [CHUNK_W-1:0] dividend;
    logic [STEP_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [CHUNK_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic {
    FR_IDLE,
    FR_SPLIT
  } front_state_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIV_RATIO,
    BK_DIV_TGT,
    BK_MUL,
    BK_ACC
  } back_state_t;

endpackage

### design/abpc_if.sv
// Valid/ready channel interfaces for the request and result sides.
// Depends on abpc_pkg.
interface abpc_in_if;
  import abpc_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [ADDR_W-1:0] start_word_address;
  logic [LEN_W-1:0]  length_words;
  logic [TGT_W-1:0]  first_target;
  logic [TGT_W-1:0]  last_target;
  logic [FAC_W-1:0]  target_step_factor;

  modport source (
    output valid, command, start_word_address, length_words,
           first_target, last_target, target_step_factor,
    input  ready
  );
  modport sink (
    input  valid, command, start_word_address, length_words,
           first_target, last_target, target_step_factor,
    output ready
  );
endinterface

interface abpc_out_if;
  import abpc_pkg::*;

  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] packet_count;

  modport source (output valid, packet_count, input ready);
  modport sink (input valid, packet_count, output ready);
endinterface

### design/abpc_front.sv
// Front end: accepts a request and splits it into runs of equal chunks.
// Depends on abpc_pkg and abpc_in_if.
module abpc_front (
  input  logic                 clk,
  input  logic                 rst_n,
  abpc_in_if.sink              in_ch,
  output abpc_pkg::chunk_desc_t q_wr_data,
  output logic                 q_wr_valid,
  input  logic                 q_wr_ready
);
  import abpc_pkg::*;

  front_state_t       state_r, state_nxt;
  logic [LEN_W-1:0]   rem_r, rem_nxt;
  logic [ALIGN_W-1:0] addr_lo_r, addr_lo_nxt;
  logic               first_r, first_nxt;
  logic               big_r, big_nxt;
  logic [CMD_W-1:0]   cmd_r, cmd_nxt;
  logic [TGT_W-1:0]   first_tgt_r, first_tgt_nxt;
  logic [TGT_W-1:0]   last_tgt_r, last_tgt_nxt;
  logic [FAC_W-1:0]   fac_r, fac_nxt;

  logic               pad;
  logic               full;
  logic [CHUNK_W-1:0] mid;
  logic [CHUNK_W-1:0] chunk;
  logic [RUN_W-1:0]   run_len;
  logic [LEN_W-1:0]   used;
  logic [LEN_W-1:0]   rem_left;
  logic               last_run;

  // Chunk selection for the current run
  always_comb begin
    pad  = first_r && (addr_lo_r != '0) && big_r;
    full = (rem_r[LEN_W-1:MAX_LOG2] != '0);
    mid  = CHUNK_W'(rem_r[MAX_LOG2-1:0]);
    priority if (pad) begin
      chunk   = CHUNK_W'(ALIGN_WORDS) - CHUNK_W'(addr_lo_r);
      run_len = RUN_W'(1);
      used    = LEN_W'(chunk);
    end else if (full) begin
      // all full-size chunks in one run
      chunk   = CHUNK_W'(MAX_PACKET_WORDS);
      run_len = rem_r[LEN_W-1:MAX_LOG2];
      used    = {rem_r[LEN_W-1:MAX_LOG2], {MAX_LOG2{1'b0}}};
    end else begin
      if (mid >= CHUNK_W'(PAD_MIN_LEN)) begin
        chunk = mid & ~CHUNK_W'(ALIGN_WORDS - 1);
      end else begin
        chunk = mid;
      end
      run_len = RUN_W'(1);
      used    = LEN_W'(chunk);
    end
    rem_left = rem_r - used;
    last_run = (rem_r == '0) || (rem_left == '0);
  end

  always_comb begin
    q_wr_data.command      = cmd_r;
    q_wr_data.first_target = first_tgt_r;
    q_wr_data.last_target  = last_tgt_r;
    q_wr_data.factor       = fac_r;
    q_wr_data.chunk        = chunk;
    q_wr_data.run_len      = run_len;
    q_wr_data.empty        = (rem_r == '0);
    q_wr_data.last_run     = last_run;
  end

  assign q_wr_valid  = (state_r == FR_SPLIT);
  assign in_ch.ready = (state_r == FR_IDLE);

  // Next state
  always_comb begin
    state_nxt     = state_r;
    rem_nxt       = rem_r;
    addr_lo_nxt   = addr_lo_r;
    first_nxt     = first_r;
    big_nxt       = big_r;
    cmd_nxt       = cmd_r;
    first_tgt_nxt = first_tgt_r;
    last_tgt_nxt  = last_tgt_r;
    fac_nxt       = fac_r;
    unique case (state_r)
      FR_IDLE: begin
        if (in_ch.valid) begin
          rem_nxt       = in_ch.length_words;
          addr_lo_nxt   = in_ch.start_word_address[ALIGN_W-1:0];
          first_nxt     = 1'b1;
          big_nxt       = (in_ch.length_words >= LEN_W'(PAD_MIN_LEN));
          cmd_nxt       = in_ch.command;
          first_tgt_nxt = in_ch.first_target;
          last_tgt_nxt  = in_ch.last_target;
          fac_nxt       = in_ch.target_step_factor;
          state_nxt     = FR_SPLIT;
        end
      end
      FR_SPLIT: begin
        if (q_wr_ready) begin
          rem_nxt     = rem_left;
          addr_lo_nxt = addr_lo_r + chunk[ALIGN_W-1:0];
          if (pad) begin
            first_nxt = 1'b0;
          end
          if (last_run) begin
            state_nxt = FR_IDLE;
          end
        end
      end
      default: state_nxt = FR_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FR_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    rem_r       <= rem_nxt;
    addr_lo_r   <= addr_lo_nxt;
    first_r     <= first_nxt;
    big_r       <= big_nxt;
    cmd_r       <= cmd_nxt;
    first_tgt_r <= first_tgt_nxt;
    last_tgt_r  <= last_tgt_nxt;
    fac_r       <= fac_nxt;
  end

endmodule

### design/abpc_queue.sv
// Short FIFO of chunk runs between the splitter and the counter.
// Depends on abpc_pkg.
module abpc_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  abpc_pkg::chunk_desc_t wr_data,
  input  logic                  wr_valid,
  output logic                  wr_ready,
  output abpc_pkg::chunk_desc_t rd_data,
  output logic                  rd_valid,
  input  logic                  rd_ready
);
  import abpc_pkg::*;

  chunk_desc_t       mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              push;
  logic              pop;

  assign wr_ready = (cnt_r != QCNT_W'(QDEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

### design/abpc_div.sv
// Restoring divider, one quotient bit per cycle, shared by the counter for
// both the chunk ratio and the division of the target span by the stride. Depends on abpc_pkg.
module abpc_div (
  input  logic               clk,
  input  logic               rst_n,
  input  abpc_pkg::div_req_t req,
  output abpc_pkg::div_rsp_t rsp
);
  import abpc_pkg::*;

  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 done_r;
  logic [CHUNK_W-1:0]   quot_r;
  logic [STEP_W-1:0]    rem_r;
  logic [STEP_W-1:0]    divisor_r;

  logic [STEP_W:0]      trial;
  logic [STEP_W:0]      diff;
  logic                 ge;

  // One shift-subtract step
  always_comb begin
    trial = {rem_r, quot_r[CHUNK_W-1]};
    diff  = trial - {1'b0, divisor_r};
    ge    = (trial >= {1'b0, divisor_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (req.start) begin
      cnt_r  <= DIV_CNT_W'(CHUNK_W);
      done_r <= 1'b0;
    end else if (cnt_r != '0) begin
      cnt_r  <= cnt_r - DIV_CNT_W'(1);
      done_r <= (cnt_r == DIV_CNT_W'(1));
    end else begin
      done_r <= 1'b0;
    end

    if (req.start) begin
      quot_r    <= req.dividend;
      rem_r     <= '0;
      divisor_r <= req.divisor;
    end else if (cnt_r != '0) begin
      quot_r <= {quot_r[CHUNK_W-2:0], ge};
      rem_r  <= ge ? diff[STEP_W-1:0] : trial[STEP_W-1:0];
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quot_r;

endmodule

### design/abpc_back.sv
// Back end: counts packets for each chunk run, accumulates per request and
// holds the result in an output register. Depends on abpc_pkg, abpc_out_if.
module abpc_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  abpc_pkg::chunk_desc_t q_rd_data,
  input  logic                  q_rd_valid,
  output logic                  q_rd_ready,
  output abpc_pkg::div_req_t    div_req,
  input  abpc_pkg::div_rsp_t    div_rsp,
  abpc_out_if.source            out_ch
);
  import abpc_pkg::*;

  back_state_t        state_r, state_nxt;
  chunk_desc_t        desc_r, desc_nxt;
  logic [PKT_W-1:0]   pkt_r, pkt_nxt;
  logic [PROD_W-1:0]  prod_r, prod_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [COUNT_W-1:0] out_count_r, out_count_nxt;

  logic [FAC_W-1:0]   fac_eff;
  logic [COUNT_W:0]   sum;
  logic [COUNT_W-1:0] sum_sat;

  assign fac_eff = (desc_r.factor == '0) ? FAC_W'(1) : desc_r.factor;

  // Saturating accumulate
  always_comb begin
    sum     = {1'b0, count_r} + (COUNT_W + 1)'(prod_r);
    sum_sat = sum[COUNT_W] ? {COUNT_W{1'b1}} : sum[COUNT_W-1:0];
  end

  assign q_rd_ready          = (state_r == BK_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.packet_count = out_count_r;

  always_comb begin
    state_nxt        = state_r;
    desc_nxt         = desc_r;
    pkt_nxt          = pkt_r;
    prod_nxt         = prod_r;
    count_nxt        = count_r;
    out_valid_nxt    = out_valid_r && !out_ch.ready;
    out_count_nxt    = out_count_r;
    div_req.start    = 1'b0;
    div_req.dividend = CHUNK_W'(MAX_PACKET_WORDS);
    div_req.divisor  = STEP_W'(q_rd_data.chunk);
    unique case (state_r)
      // take the next run and classify it
      BK_IDLE: begin
        if (q_rd_valid) begin
          desc_nxt = q_rd_data;
          priority if (q_rd_data.empty) begin
            pkt_nxt   = '0;
            state_nxt = BK_MUL;
          end else if (q_rd_data.command == CMD_SAME_WRITE) begin
            pkt_nxt   = PKT_W'(1);
            state_nxt = BK_MUL;
          end else if (q_rd_data.command != CMD_SEQ ||
                       q_rd_data.last_target < q_rd_data.first_target) begin
            pkt_nxt   = '0;
            state_nxt = BK_MUL;
          end else begin
            div_req.start = 1'b1;
            state_nxt     = BK_DIV_RATIO;
          end
        end
      end
      // MAX / chunk done: stride = ratio * factor, then span / stride
      BK_DIV_RATIO: begin
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = CHUNK_W'(desc_r.last_target - desc_r.first_target);
          div_req.divisor  = STEP_W'(div_rsp.quotient) * STEP_W'(fac_eff);
          state_nxt        = BK_DIV_TGT;
        end
      end
      BK_DIV_TGT: begin
        if (div_rsp.done) begin
          pkt_nxt   = PKT_W'(div_rsp.quotient) + PKT_W'(1);
          state_nxt = BK_MUL;
        end
      end
      BK_MUL: begin
        prod_nxt  = PROD_W'(pkt_r) * PROD_W'(desc_r.run_len);
        state_nxt = BK_ACC;
      end
      BK_ACC: begin
        if (!desc_r.last_run) begin
          count_nxt = sum_sat;
          state_nxt = BK_IDLE;
        end else if (!out_valid_r || out_ch.ready) begin
          out_count_nxt = sum_sat;
          out_valid_nxt = 1'b1;
          count_nxt     = '0;
          state_nxt     = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    desc_r      <= desc_nxt;
    pkt_r       <= pkt_nxt;
    prod_r      <= prod_nxt;
    out_count_r <= out_count_nxt;
  end

endmodule

### design/aligned_burst_packet_counter_core.sv
// Aligned burst packet counter: splitter front end, 4-entry run queue,
// counting back end with a shared bit-serial divider.
// A request becomes at most four runs (pad, full-size, middle, tail); sequential
// runs take two divisions on the shared divider, other runs none. The front end
// can accept a new request once the last run of the previous one is queued,
// while the back end may still be counting it. Sync active-low reset.
module aligned_burst_packet_counter_core (
  input  logic       clk,
  input  logic       rst_n,
  abpc_in_if.sink    in_ch,
  abpc_out_if.source out_ch
);
  import abpc_pkg::*;

  chunk_desc_t q_wr_data;
  logic        q_wr_valid;
  logic        q_wr_ready;
  chunk_desc_t q_rd_data;
  logic        q_rd_valid;
  logic        q_rd_ready;
  div_req_t    div_req;
  div_rsp_t    div_rsp;

  abpc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .q_wr_data  (q_wr_data),
    .q_wr_valid (q_wr_valid),
    .q_wr_ready (q_wr_ready)
  );

  abpc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_data  (q_wr_data),
    .wr_valid (q_wr_valid),
    .wr_ready (q_wr_ready),
    .rd_data  (q_rd_data),
    .rd_valid (q_rd_valid),
    .rd_ready (q_rd_ready)
  );

  abpc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  abpc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_rd_data  (q_rd_data),
    .q_rd_valid (q_rd_valid),
    .q_rd_ready (q_rd_ready),
    .div_req    (div_req),
    .div_rsp    (div_rsp),
    .out_ch     (out_ch)
  );

endmodule
